// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ===== hw/rtl/nawt_pkg.sv =====
package nawt_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int UID_W  = 64;
    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 4;
    localparam int STAT_W = 3;
    localparam int OP_W   = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    // item kinds
    localparam logic [OP_W-1:0] OP_ANNOUNCE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
    localparam logic [OP_W-1:0] OP_ASSIGN   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_NEW       = 3'd1;
    localparam logic [STAT_W-1:0] ST_REFRESHED = 3'd2;
    localparam logic [STAT_W-1:0] ST_TICK      = 3'd3;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd4;
    localparam logic [STAT_W-1:0] ST_REFUSED   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORGET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROV_LO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROV_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ASGN_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ASGN_HI  = 3'd4;

    localparam logic [TIME_W-1:0] FORGET_RST = 32'd10000;

    typedef struct packed {
        logic load;    // latch a new item, clear scan state
        logic step;    // visit one table entry
        logic finish;  // commit and present the result
    } ctrl_cmd_t;

    typedef struct packed {
        logic skip;    // item needs no table scan
        logic last;    // scan index is on the final entry
    } dp_stat_t;

endpackage

// ===== hw/rtl/nawt_ctrl.sv =====
module nawt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  nawt_pkg::dp_stat_t  stat,
    output nawt_pkg::ctrl_cmd_t cmd,
    output logic                busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.skip)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.last)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hw/rtl/nawt_datapath.sv =====
module nawt_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  nawt_pkg::ctrl_cmd_t                   cmd,
    output nawt_pkg::dp_stat_t                    stat,
    input  logic                                  cfg_write,
    input  logic [nawt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nawt_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [nawt_pkg::OP_W-1:0]             opcode,
    input  logic [nawt_pkg::UID_W-1:0]            node_uid,
    input  logic [nawt_pkg::ID_W-1:0]             node_id,
    input  logic [nawt_pkg::TIME_W-1:0]           now_ms,
    output logic                                  done,
    output logic [nawt_pkg::STAT_W-1:0]           status,
    output logic [nawt_pkg::ID_W-1:0]             target_id,
    output logic [nawt_pkg::ID_W-1:0]             new_id,
    output logic [nawt_pkg::CNT_W-1:0]            expired_count
);

    localparam int N = nawt_pkg::TABLE_ENTRIES;
    localparam int IW = nawt_pkg::IDX_W;

    // configuration
    logic [nawt_pkg::TIME_W-1:0] forget_reg;
    logic [nawt_pkg::ID_W-1:0]   prov_lo_reg;
    logic [nawt_pkg::ID_W-1:0]   prov_hi_reg;
    logic [nawt_pkg::ID_W-1:0]   asgn_lo_reg;
    logic [nawt_pkg::ID_W-1:0]   asgn_hi_reg;

    // table
    logic                        slot_valid_reg [N];
    logic [nawt_pkg::TIME_W-1:0] slot_lh_reg    [N];
    logic [nawt_pkg::UID_W-1:0]  slot_uid_reg   [N];
    logic [nawt_pkg::ID_W-1:0]   slot_prov_reg  [N];

    // latched item
    logic [nawt_pkg::OP_W-1:0]   op_reg;
    logic [nawt_pkg::UID_W-1:0]  uid_reg;
    logic [nawt_pkg::ID_W-1:0]   id_reg;
    logic [nawt_pkg::TIME_W-1:0] now_reg;

    // scan state
    logic [IW-1:0]               idx_reg;
    logic                        found_reg;
    logic [IW-1:0]               found_idx_reg;
    logic [nawt_pkg::ID_W-1:0]   hit_prov_reg;
    logic                        free_reg;
    logic [IW-1:0]               free_idx_reg;
    logic [IW-1:0]               oldest_idx_reg;
    logic [nawt_pkg::TIME_W-1:0] oldest_lh_reg;
    logic [nawt_pkg::CNT_W-1:0]  count_reg;

    logic                        cur_valid;
    logic [nawt_pkg::TIME_W-1:0] cur_lh;
    logic                        cur_match;
    logic [nawt_pkg::TIME_W-1:0] elapsed;
    logic                        cur_expire;
    logic                        prov_ok;
    logic                        asgn_ok;
    logic                        skip;
    logic                        commit;
    logic [IW-1:0]               pick_idx;

    assign cur_valid  = slot_valid_reg[idx_reg];
    assign cur_lh     = slot_lh_reg[idx_reg];
    assign cur_match  = cur_valid && (slot_uid_reg[idx_reg] == uid_reg);
    assign elapsed    = now_reg - cur_lh;
    assign cur_expire = cur_valid && (elapsed >= forget_reg);

    assign prov_ok = (id_reg >= prov_lo_reg) && (id_reg <= prov_hi_reg);
    assign asgn_ok = (id_reg >= asgn_lo_reg) && (id_reg <= asgn_hi_reg);
    assign skip    = ((op_reg == nawt_pkg::OP_ANNOUNCE) && !prov_ok)
                  || ((op_reg == nawt_pkg::OP_ASSIGN) && !asgn_ok)
                  || (op_reg == nawt_pkg::OP_RESERVED);

    assign stat.skip = skip;
    assign stat.last = (idx_reg == IW'(N - 1));

    assign commit   = cmd.finish && (op_reg == nawt_pkg::OP_ANNOUNCE) && !skip;
    // existing entry first, then first free entry, then the oldest one
    assign pick_idx = found_reg ? found_idx_reg
                    : (free_reg ? free_idx_reg : oldest_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forget_reg  <= nawt_pkg::FORGET_RST;
            prov_lo_reg <= '0;
            prov_hi_reg <= '1;
            asgn_lo_reg <= '0;
            asgn_hi_reg <= '1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                nawt_pkg::REG_FORGET:  forget_reg  <= cfg_data;
                nawt_pkg::REG_PROV_LO: prov_lo_reg <= cfg_data[nawt_pkg::ID_W-1:0];
                nawt_pkg::REG_PROV_HI: prov_hi_reg <= cfg_data[nawt_pkg::ID_W-1:0];
                nawt_pkg::REG_ASGN_LO: asgn_lo_reg <= cfg_data[nawt_pkg::ID_W-1:0];
                nawt_pkg::REG_ASGN_HI: asgn_hi_reg <= cfg_data[nawt_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits and last-heard times reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
                slot_lh_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cmd.step && (op_reg == nawt_pkg::OP_TICK) && cur_expire)
            begin
                slot_valid_reg[idx_reg] <= 1'b0;
            end
            if (commit)
            begin
                slot_valid_reg[pick_idx] <= 1'b1;
                slot_lh_reg[pick_idx]    <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            slot_uid_reg[pick_idx]  <= uid_reg;
            slot_prov_reg[pick_idx] <= id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            uid_reg <= node_uid;
            id_reg  <= node_id;
            now_reg <= now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            found_idx_reg  <= '0;
            hit_prov_reg   <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            oldest_idx_reg <= '0;
            oldest_lh_reg  <= '1;
            count_reg      <= '0;
        end
        else if (cmd.load)
        begin
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_reg       <= 1'b0;
            oldest_idx_reg <= '0;
            oldest_lh_reg  <= '1;
            count_reg      <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg <= IW'(idx_reg + 1'b1);
            if (!found_reg && cur_match)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= idx_reg;
                hit_prov_reg  <= slot_prov_reg[idx_reg];
            end
            if (!free_reg && !cur_valid)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= idx_reg;
            end
            // strict compare keeps the first of equal times
            if (cur_lh < oldest_lh_reg)
            begin
                oldest_lh_reg  <= cur_lh;
                oldest_idx_reg <= idx_reg;
            end
            if ((op_reg == nawt_pkg::OP_TICK) && cur_expire && (count_reg != nawt_pkg::CNT_MAX))
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status        <= nawt_pkg::ST_IGNORED;
            target_id     <= '0;
            new_id        <= '0;
            expired_count <= '0;
            unique case (op_reg)
                nawt_pkg::OP_ANNOUNCE:
                begin
                    if (!skip)
                    begin
                        status <= found_reg ? nawt_pkg::ST_REFRESHED : nawt_pkg::ST_NEW;
                    end
                end
                nawt_pkg::OP_TICK:
                begin
                    status        <= nawt_pkg::ST_TICK;
                    expired_count <= count_reg;
                end
                nawt_pkg::OP_ASSIGN:
                begin
                    if (!skip && found_reg)
                    begin
                        status    <= nawt_pkg::ST_FOUND;
                        target_id <= hit_prov_reg;
                        new_id    <= id_reg;
                    end
                    else
                    begin
                        status <= nawt_pkg::ST_REFUSED;
                    end
                end
                nawt_pkg::OP_RESERVED:
                begin
                    status <= nawt_pkg::ST_IGNORED;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/node_announce_wait_table.sv =====
// Announce, tick and assign items are latched on the accepting edge, scan the
// table, then pass the finish state, which registers the done strobe; an item
// that needs no scan (id out of range, reserved opcode) skips the table walk.
// No new item is taken while busy; the scan visits one table entry per cycle.
// Reset clears valid bits and last-heard times and loads configuration defaults.
// One result per item, strobed by done for one cycle; the receiver cannot stall.
module node_announce_wait_table (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  cfg_write,
    input  logic [nawt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nawt_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [nawt_pkg::OP_W-1:0]             opcode,
    input  logic [nawt_pkg::UID_W-1:0]            node_uid,
    input  logic [nawt_pkg::ID_W-1:0]             node_id,
    input  logic [nawt_pkg::TIME_W-1:0]           now_ms,
    output logic                                  done,
    output logic [nawt_pkg::STAT_W-1:0]           status,
    output logic [nawt_pkg::ID_W-1:0]             target_id,
    output logic [nawt_pkg::ID_W-1:0]             new_id,
    output logic [nawt_pkg::CNT_W-1:0]            expired_count
);

    nawt_pkg::ctrl_cmd_t cmd;
    nawt_pkg::dp_stat_t  stat;

    nawt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    nawt_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .node_uid      (node_uid),
        .node_id       (node_id),
        .now_ms        (now_ms),
        .done          (done),
        .status        (status),
        .target_id     (target_id),
        .new_id        (new_id),
        .expired_count (expired_count)
    );

endmodule

// ===== hw/rtl/nawt_checker.sv =====
`include "assert_macros.svh"

module nawt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic [nawt_pkg::STAT_W-1:0]      status,
    input logic [nawt_pkg::CNT_W-1:0]       expired_count
);

    // an accepted item keeps the block busy in the next cycle
    `ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // the block is idle while its result is shown
    `ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    // the end of busy always comes with a result
    `ASSERT_IMP(a_fall_done, clk, rst_n, $fell(busy), done)
    // one result per item: never two strobes in a row
    `ASSERT_NXT(a_done_single, clk, rst_n, done, !done)
    // only ticks report expired entries
    `ASSERT_IMP(a_count_tick, clk, rst_n, done && (status != nawt_pkg::ST_TICK),
                expired_count == '0)

endmodule

bind node_announce_wait_table nawt_checker u_nawt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .expired_count (expired_count)
);

// ===== tb/sv/tb_node_announce_wait_table.sv =====
`timescale 1ns / 1ps

module tb_node_announce_wait_table;

    import nawt_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [UID_W-1:0]  uid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   target;
        logic [ID_W-1:0]   new_id;
        logic [CNT_W-1:0]  expired;
    } result_t;

    localparam int POOL_SIZE = 12;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic [OP_W-1:0]       opcode = '0;
    logic [UID_W-1:0]      node_uid = '0;
    logic [ID_W-1:0]       node_id = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic                  done;
    logic [STAT_W-1:0]     status;
    logic [ID_W-1:0]       target_id;
    logic [ID_W-1:0]       new_id;
    logic [CNT_W-1:0]      expired_count;

    node_announce_wait_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .node_uid      (node_uid),
        .node_id       (node_id),
        .now_ms        (now_ms),
        .done          (done),
        .status        (status),
        .target_id     (target_id),
        .new_id        (new_id),
        .expired_count (expired_count)
    );

    always #1 clk = ~clk;

    // local copy of the block's registers and wait table
    logic [TIME_W-1:0] cfg_forget  = FORGET_RST;
    logic [ID_W-1:0]   cfg_prov_lo = '0;
    logic [ID_W-1:0]   cfg_prov_hi = '1;
    logic [ID_W-1:0]   cfg_asgn_lo = '0;
    logic [ID_W-1:0]   cfg_asgn_hi = '1;

    logic              tbl_valid [TABLE_ENTRIES];
    logic [UID_W-1:0]  tbl_uid   [TABLE_ENTRIES];
    logic [ID_W-1:0]   tbl_prov  [TABLE_ENTRIES];
    logic [TIME_W-1:0] tbl_heard [TABLE_ENTRIES];

    item_t   pending_items[$];
    result_t expected_results[$];
    int      errors = 0;
    logic    taken = 1'b0;

    logic [UID_W-1:0]  uid_pool [POOL_SIZE];
    logic [TIME_W-1:0] sim_ms;

    initial
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_uid[i]   = '0;
            tbl_prov[i]  = '0;
            tbl_heard[i] = '0;
        end
    end

    function automatic int lookup_uid(input logic [UID_W-1:0] uid);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i] && tbl_uid[i] == uid)
                return i;
        return -1;
    endfunction

    function automatic result_t predict_result(input item_t it);
        result_t r;
        int pick;
        int oldest;
        int free_slot;
        logic [TIME_W-1:0] age;
        r = '0;
        case (it.opcode)
            OP_ANNOUNCE:
            begin
                r.status = ST_IGNORED;
                if (it.id >= cfg_prov_lo && it.id <= cfg_prov_hi)
                begin
                    pick = lookup_uid(it.uid);
                    if (pick < 0)
                    begin
                        oldest = 0;
                        free_slot = -1;
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                        begin
                            if (!tbl_valid[i] && free_slot < 0)
                                free_slot = i;
                            // plain compare, no wrap
                            if (tbl_heard[i] < tbl_heard[oldest])
                                oldest = i;
                        end
                        pick = (free_slot >= 0) ? free_slot : oldest;
                    end
                    r.status = (!tbl_valid[pick] || tbl_uid[pick] != it.uid) ? ST_NEW
                                                                              : ST_REFRESHED;
                    tbl_uid[pick]   = it.uid;
                    tbl_prov[pick]  = it.id;
                    tbl_heard[pick] = it.now;
                    tbl_valid[pick] = 1'b1;
                end
            end
            OP_TICK:
            begin
                r.status = ST_TICK;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    age = it.now - tbl_heard[i];
                    if (tbl_valid[i] && age >= cfg_forget)
                    begin
                        tbl_valid[i] = 1'b0;
                        if (r.expired != CNT_MAX)
                            r.expired = r.expired + 1'b1;
                    end
                end
            end
            OP_ASSIGN:
            begin
                r.status = ST_REFUSED;
                if (it.id >= cfg_asgn_lo && it.id <= cfg_asgn_hi)
                begin
                    pick = lookup_uid(it.uid);
                    if (pick >= 0)
                    begin
                        r.status = ST_FOUND;
                        r.target = tbl_prov[pick];
                        r.new_id = it.id;
                    end
                end
            end
            default:
                r.status = ST_IGNORED;
        endcase
        return r;
    endfunction

    // item driver: bursts of items separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        item_t nxt;
        if (rst_n && (!start || taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                nxt = pending_items.pop_front();
                opcode   <= nxt.opcode;
                node_uid <= nxt.uid;
                node_id  <= nxt.id;
                now_ms   <= nxt.now;
                start    <= 1'b1;
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
                end
            end
            else
                start <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // result monitor; also predicts each accepted item
    always @(posedge clk)
    begin
        result_t want;
        taken = rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got status %0h",
                         $time, status);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("target_id", 32'(want.target), 32'(target_id));
                check_field("new_id", 32'(want.new_id), 32'(new_id));
                check_field("expired_count", 32'(want.expired), 32'(expired_count));
            end
        end
        if (taken)
            expected_results.push_back(predict_result({opcode, node_uid, node_id, now_ms}));
    end

    task automatic post_item(input logic [OP_W-1:0] op, input logic [UID_W-1:0] uid,
                             input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now);
        item_t it;
        it.opcode = op;
        it.uid = uid;
        it.id = id;
        it.now = now;
        pending_items.push_back(it);
    endtask

    // wait until every item is out and answered, then let the block go quiet
    task automatic settle();
        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_ENTRIES + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_FORGET:  cfg_forget  = data;
            REG_PROV_LO: cfg_prov_lo = data[ID_W-1:0];
            REG_PROV_HI: cfg_prov_hi = data[ID_W-1:0];
            REG_ASGN_LO: cfg_asgn_lo = data[ID_W-1:0];
            REG_ASGN_HI: cfg_asgn_hi = data[ID_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [TIME_W-1:0] forget,
                              input logic [ID_W-1:0] plo, input logic [ID_W-1:0] phi,
                              input logic [ID_W-1:0] alo, input logic [ID_W-1:0] ahi);
        write_reg(REG_FORGET, forget);
        write_reg(REG_PROV_LO, CFG_DATA_W'(plo));
        write_reg(REG_PROV_HI, CFG_DATA_W'(phi));
        write_reg(REG_ASGN_LO, CFG_DATA_W'(alo));
        write_reg(REG_ASGN_HI, CFG_DATA_W'(ahi));
    endtask

    // mostly well-formed traffic on a small pool of nodes with a moving clock
    task automatic post_random_item();
        int roll;
        logic [OP_W-1:0]  op;
        logic [UID_W-1:0] uid;
        logic [ID_W-1:0]  id;
        logic [TIME_W-1:0] now;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            op = OP_ANNOUNCE;
        else if (roll < 70)
            op = OP_TICK;
        else if (roll < 95)
            op = OP_ASSIGN;
        else
            op = OP_RESERVED;
        if ($urandom_range(0, 9) != 0)
            uid = uid_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            uid = {$urandom, $urandom};
        id = 16'($urandom);
        if ($urandom_range(0, 19) != 0)
        begin
            if (op == OP_ANNOUNCE && cfg_prov_lo <= cfg_prov_hi)
                id = 16'($urandom_range(cfg_prov_hi, cfg_prov_lo));
            else if (op == OP_ASSIGN && cfg_asgn_lo <= cfg_asgn_hi)
                id = 16'($urandom_range(cfg_asgn_hi, cfg_asgn_lo));
        end
        sim_ms = sim_ms + $urandom_range(0, 400);
        now = ($urandom_range(0, 19) == 0) ? $urandom : sim_ms;
        post_item(op, uid, id, now);
    endtask

    initial
    begin
        logic [UID_W-1:0] d_uid [9];
        logic [TIME_W-1:0] forget;
        logic [ID_W-1:0] plo, phi, alo, ahi;
        int left;
        int chunk;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: reset settings
        d_uid[0] = '0;
        for (int k = 1; k < 8; k++)
            d_uid[k] = {$urandom, $urandom};
        d_uid[7] = '1;
        d_uid[8] = 64'h0123_4567_89ab_cdef;
        post_item(OP_RESERVED, '1, '1, '1);
        post_item(OP_ASSIGN, d_uid[0], 16'h1234, '0);     // empty table
        post_item(OP_ANNOUNCE, d_uid[0], 16'h0000, 32'd100);
        post_item(OP_ANNOUNCE, d_uid[0], 16'hffff, 32'd200); // refresh
        post_item(OP_ASSIGN, d_uid[0], 16'hffff, '0);
        for (int k = 1; k < 8; k++)
            post_item(OP_ANNOUNCE, d_uid[k], 16'(k), 32'(300 + 10 * k));
        // table full: victims are the smallest times, no wrap
        post_item(OP_ANNOUNCE, d_uid[8], 16'h00aa, 32'hffff_fff0);
        post_item(OP_ANNOUNCE, ~d_uid[8], 16'h00bb, 32'd5);
        post_item(OP_TICK, '0, '0, 32'd10330);            // age equal to forget time
        post_item(OP_ASSIGN, d_uid[1], 16'h0001, '0);     // evicted earlier, refused
        post_item(OP_ASSIGN, d_uid[7], 16'h0000, '0);
        settle();

        set_limits('0, 16'd10, 16'd20, 16'd100, 16'd100);
        post_item(OP_ANNOUNCE, d_uid[2], 16'd9, 32'd50);
        post_item(OP_ANNOUNCE, d_uid[2], 16'd10, 32'd50);
        post_item(OP_ANNOUNCE, d_uid[3], 16'd20, 32'd60);
        post_item(OP_ANNOUNCE, d_uid[4], 16'd21, 32'd60);
        post_item(OP_ASSIGN, d_uid[2], 16'd99, '0);
        post_item(OP_ASSIGN, d_uid[2], 16'd100, '0);
        post_item(OP_ASSIGN, d_uid[3], 16'd101, '0);
        post_item(OP_TICK, '0, '0, 32'd60);               // zero forget time drops all
        settle();

        set_limits('1, 16'd20, 16'd10, 16'hffff, 16'h0000);
        post_item(OP_ANNOUNCE, d_uid[5], 16'd15, 32'd0);
        post_item(OP_ASSIGN, d_uid[5], 16'hffff, '0);
        post_item(OP_TICK, '0, '0, '1);
        settle();

        // random phases, each split into chunks drained in between
        for (int p = 0; p < 6; p++)
        begin
            for (int k = 0; k < POOL_SIZE; k++)
                uid_pool[k] = {$urandom, $urandom};
            sim_ms = (p == 2) ? 32'hffff_f000 : $urandom;
            forget = (p == 1) ? '0 : (p == 4) ? '1 : $urandom_range(4000, 200);
            plo = (p == 0) ? 16'h0000 : 16'($urandom_range(16'h4000, 0));
            phi = (p == 0) ? 16'hffff : 16'($urandom_range(16'hffff, 16'hc000));
            if (p == 2)
                phi = plo;
            alo = (p == 3) ? 16'h0000 : 16'($urandom_range(16'h4000, 0));
            ahi = (p == 3) ? 16'hffff : 16'($urandom_range(16'hffff, 16'hc000));
            set_limits(forget, plo, phi, alo, ahi);
            left = 140;
            while (left > 0)
            begin
                chunk = $urandom_range(60, 20);
                if (chunk > left)
                    chunk = left;
                for (int n = 0; n < chunk; n++)
                    post_random_item();
                left = left - chunk;
                settle();
            end
        end

        settle();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/nawt_pkg.sv
hw/rtl/nawt_ctrl.sv
hw/rtl/nawt_datapath.sv
hw/rtl/node_announce_wait_table.sv
hw/rtl/nawt_checker.sv
tb/sv/tb_node_announce_wait_table.sv
